// ===== design/psu_pkg.sv =====
// Package: constants, widths, codes and shared types for the PNG scanline unfilter.
`timescale 1ns / 1ps
package psu_pkg;

  localparam int MAX_WIDTH       = 1024;
  localparam int BYTES_PER_PIXEL = 4;
  localparam int STORE_DEPTH     = MAX_WIDTH * BYTES_PER_PIXEL;

  localparam int BYTE_W   = 8;
  localparam int WIDTH_W  = 11;
  localparam int HEIGHT_W = 16;
  localparam int COL_W    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CH_W     = (BYTES_PER_PIXEL > 1) ? $clog2(BYTES_PER_PIXEL) : 1;
  localparam int MAXW_W   = $clog2(MAX_WIDTH + 1);
  localparam int WEFF_W   = (WIDTH_W > MAXW_W) ? WIDTH_W : MAXW_W;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;

  localparam logic [BYTE_W-1:0] FILT_NONE  = 8'd0;
  localparam logic [BYTE_W-1:0] FILT_SUB   = 8'd1;
  localparam logic [BYTE_W-1:0] FILT_UP    = 8'd2;
  localparam logic [BYTE_W-1:0] FILT_AVG   = 8'd3;
  localparam logic [BYTE_W-1:0] FILT_PAETH = 8'd4;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] raw;
    logic [BYTE_W-1:0] filter;
    logic [COL_W-1:0]  col;
    logic [CH_W-1:0]   ch;
    logic              first_row;
    logic              left_ok;
    logic              last_col;
    logic              last_row;
  } stage_t;

  typedef struct packed {
    logic              en;
    logic [COL_W-1:0]  addr;
    logic [BYTE_W-1:0] data;
  } store_wr_t;

endpackage

// ===== design/psu_ifs.sv =====
// Interfaces: input byte channel, output pixel channel and configuration write channel.
`timescale 1ns / 1ps
interface psu_byte_if;
  import psu_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] stream_byte;
  modport source (output valid, output stream_byte, input ready);
  modport sink (input valid, input stream_byte, output ready);
endinterface

interface psu_pix_if;
  import psu_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] pixel_byte;
  logic              row_end;
  logic              image_end;
  modport source (output valid, output pixel_byte, output row_end, output image_end,
                  input ready);
  modport sink (input valid, input pixel_byte, input row_end, input image_end,
                output ready);
endinterface

interface psu_cfg_if;
  import psu_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output reg_index, output data, input ready);
  modport sink (input valid, input reg_index, input data, output ready);
endinterface

// ===== design/psu_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module psu_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/psu_ctrl.sv =====
// Control: configuration registers, row and column counters, input stage register.
`timescale 1ns / 1ps
module psu_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  input  logic [psu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [psu_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                          cfg_ready,
  input  logic                          in_valid,
  input  logic [psu_pkg::BYTE_W-1:0]    in_byte,
  output logic                          in_ready,
  input  logic                          adv,
  output psu_pkg::stage_t               stage,
  output logic                          rd_en,
  output logic [psu_pkg::COL_W-1:0]     rd_addr
);
  import psu_pkg::*;

  logic [WIDTH_W-1:0]  image_width;
  logic [HEIGHT_W-1:0] image_height;
  logic                awaiting;
  logic [BYTE_W-1:0]   row_filter;
  logic [COL_W-1:0]    col;
  logic [CH_W-1:0]     ch;
  logic [HEIGHT_W-1:0] row;

  logic [WEFF_W-1:0]   w_ext;
  logic [WEFF_W-1:0]   w_eff;
  logic [COL_W:0]      row_bytes;
  logic [HEIGHT_W-1:0] h_last;
  logic                last_col;
  logic                last_row;
  logic                accept;
  logic                sample;

  assign cfg_ready = 1'b1;
  assign in_ready  = !stage.valid || adv;
  assign accept    = in_valid && in_ready;
  assign sample    = accept && !awaiting;
  assign rd_en     = sample;
  assign rd_addr   = col;

  always_comb begin
    w_ext = WEFF_W'(image_width);
    if (w_ext == '0) begin
      w_eff = WEFF_W'(1);
    end else if (w_ext > WEFF_W'(MAX_WIDTH)) begin
      w_eff = WEFF_W'(MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    row_bytes = (COL_W+1)'(w_eff * BYTES_PER_PIXEL);
    h_last    = (image_height == '0) ? '0 : image_height - HEIGHT_W'(1);
    last_col  = ({1'b0, col} + (COL_W+1)'(1)) >= row_bytes;
    last_row  = row >= h_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_W'(1);
      image_height <= HEIGHT_W'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  image_width  <= cfg_data[WIDTH_W-1:0];
        CFG_IMAGE_HEIGHT: image_height <= cfg_data[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      awaiting   <= 1'b1;
      row_filter <= FILT_NONE;
      col        <= '0;
      ch         <= '0;
      row        <= '0;
    end else if (accept) begin
      if (awaiting) begin
        row_filter <= in_byte;
        awaiting   <= 1'b0;
        col        <= '0;
        ch         <= '0;
      end else if (last_col) begin
        col      <= '0;
        ch       <= '0;
        awaiting <= 1'b1;
        row      <= last_row ? '0 : row + HEIGHT_W'(1);
      end else begin
        col <= col + COL_W'(1);
        ch  <= (ch == CH_W'(BYTES_PER_PIXEL - 1)) ? '0 : ch + CH_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (sample) begin
      stage.valid <= 1'b1;
    end else if (adv) begin
      stage.valid <= 1'b0;
    end
    if (sample) begin
      stage.raw       <= in_byte;
      stage.filter    <= row_filter;
      stage.col       <= col;
      stage.ch        <= ch;
      stage.first_row <= (row == '0);
      stage.left_ok   <= (col >= COL_W'(BYTES_PER_PIXEL));
      stage.last_col  <= last_col;
      stage.last_row  <= last_row;
    end
  end

endmodule

// ===== design/psu_recon.sv =====
// Reconstruction: predictor selection, neighbour registers and output register.
`timescale 1ns / 1ps
module psu_recon (
  input  logic                       clk,
  input  logic                       rst,
  input  psu_pkg::stage_t            stage,
  input  logic [psu_pkg::BYTE_W-1:0] rd_data,
  output logic                       adv,
  output psu_pkg::store_wr_t         wr,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [psu_pkg::BYTE_W-1:0] pixel_byte,
  output logic                       row_end,
  output logic                       image_end
);
  import psu_pkg::*;

  logic [BYTE_W-1:0] left_bytes [BYTES_PER_PIXEL];
  logic [BYTE_W-1:0] ul_bytes [BYTES_PER_PIXEL];

  logic [BYTE_W-1:0] a;
  logic [BYTE_W-1:0] b;
  logic [BYTE_W-1:0] c;
  logic [BYTE_W-1:0] pa;
  logic [BYTE_W-1:0] pb;
  logic signed [BYTE_W+1:0] p_sum;
  logic [BYTE_W:0]   pc;
  logic [BYTE_W:0]   avg_sum;
  logic [BYTE_W-1:0] paeth;
  logic [BYTE_W-1:0] pred;
  logic [BYTE_W-1:0] value;
  logic              step;

  assign adv  = !out_valid || out_ready;
  assign step = stage.valid && adv;

  always_comb begin
    a = stage.left_ok ? left_bytes[stage.ch] : '0;
    b = stage.first_row ? '0 : rd_data;
    c = (!stage.first_row && stage.left_ok) ? ul_bytes[stage.ch] : '0;
    pa = (b >= c) ? b - c : c - b;
    pb = (a >= c) ? a - c : c - a;
    p_sum = $signed({2'b00, a}) + $signed({2'b00, b}) - $signed({1'b0, c, 1'b0});
    pc = p_sum[BYTE_W+1] ? (BYTE_W+1)'(0) - p_sum[BYTE_W:0] : p_sum[BYTE_W:0];
    if ({1'b0, pa} <= {1'b0, pb} && {1'b0, pa} <= pc) begin
      paeth = a;
    end else if ({1'b0, pb} <= pc) begin
      paeth = b;
    end else begin
      paeth = c;
    end
    avg_sum = {1'b0, a} + {1'b0, b};
    case (stage.filter)
      FILT_SUB:   pred = a;
      FILT_UP:    pred = b;
      FILT_AVG:   pred = avg_sum[BYTE_W:1];
      FILT_PAETH: pred = paeth;
      default:    pred = '0;
    endcase
    value = stage.raw + pred;
  end

  assign wr.en   = step;
  assign wr.addr = stage.col;
  assign wr.data = value;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < BYTES_PER_PIXEL; i++) begin
        left_bytes[i] <= '0;
        ul_bytes[i]   <= '0;
      end
    end else if (step) begin
      left_bytes[stage.ch] <= value;
      ul_bytes[stage.ch]   <= b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= stage.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      pixel_byte <= value;
      row_end    <= stage.last_col;
      image_end  <= stage.last_col && stage.last_row;
    end
  end

endmodule

// ===== design/png_scanline_unfilter_core.sv =====
// Top level: PNG scanline unfilter for RGBA8, one byte per cycle unless output stalls.
//
//   channel   dir   payload                                 handshake
//   byte_in   in    stream_byte[7:0]                        valid / ready
//   pix_out   out   pixel_byte[7:0], row_end, image_end     valid / ready
//   cfg       in    reg_index[0], data[15:0]                valid / ready (ready always 1)
//
// One byte accepted per cycle unless pix_out stalls; each sample byte goes through the
// stage register, beside the registered line-store read, and then the output register.
// Filter-type bytes produce no beat. Reset is synchronous; the line store is not cleared.
// A stalled output holds its beat while the stage register can still take one more byte.
`timescale 1ns / 1ps
module png_scanline_unfilter_core (
  input logic          clk,
  input logic          rst,
  psu_byte_if.sink     byte_in,
  psu_pix_if.source    pix_out,
  psu_cfg_if.sink      cfg
);
  import psu_pkg::*;

  stage_t            stage;
  store_wr_t         wr;
  logic              adv;
  logic              rd_en;
  logic [COL_W-1:0]  rd_addr;
  logic [BYTE_W-1:0] rd_data;

  psu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg.valid),
    .cfg_index (cfg.reg_index),
    .cfg_data  (cfg.data),
    .cfg_ready (cfg.ready),
    .in_valid  (byte_in.valid),
    .in_byte   (byte_in.stream_byte),
    .in_ready  (byte_in.ready),
    .adv       (adv),
    .stage     (stage),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr)
  );

  psu_ram #(
    .DEPTH (STORE_DEPTH),
    .WIDTH (BYTE_W)
  ) u_line_store (
    .clk   (clk),
    .we    (wr.en),
    .waddr (wr.addr),
    .wdata (wr.data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  psu_recon u_recon (
    .clk        (clk),
    .rst        (rst),
    .stage      (stage),
    .rd_data    (rd_data),
    .adv        (adv),
    .wr         (wr),
    .out_valid  (pix_out.valid),
    .out_ready  (pix_out.ready),
    .pixel_byte (pix_out.pixel_byte),
    .row_end    (pix_out.row_end),
    .image_end  (pix_out.image_end)
  );

endmodule

// ===== design/psu_checker.sv =====
// Checker: port-level assertions for the scanline unfilter, bound to the top level.
`timescale 1ns / 1ps
module psu_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [psu_pkg::BYTE_W-1:0] pixel_byte,
  input logic                       row_end,
  input logic                       image_end
);
  import psu_pkg::*;

  logic in_beat;
  assign in_beat = in_valid && in_ready;

  a_image_end_on_row_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && image_end |-> row_end)
    else $error("image_end without row_end");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pixel_byte) && $stable(row_end)
      && $stable(image_end))
    else $error("stalled output beat changed");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (!in_beat && out_ready) ##1 (!in_beat && out_ready) |=> !out_valid)
    else $error("output beat without a matching input byte");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind png_scanline_unfilter_core psu_checker u_psu_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (byte_in.valid),
  .in_ready   (byte_in.ready),
  .out_valid  (pix_out.valid),
  .out_ready  (pix_out.ready),
  .pixel_byte (pix_out.pixel_byte),
  .row_end    (pix_out.row_end),
  .image_end  (pix_out.image_end)
);

// ===== tb/sv/tb.sv =====
// Testbench for the PNG scanline unfilter core: directed and random byte streams checked beat by beat.
`timescale 1ns / 1ps
module tb;
  import psu_pkg::*;

  localparam int unsigned MAX_CYCLES   = 400_000;
  localparam int unsigned DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [BYTE_W-1:0] pixel_byte;
    logic              row_end;
    logic              image_end;
  } pixel_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  psu_byte_if byte_bus ();
  psu_pix_if  pix_bus ();
  psu_cfg_if  cfg_bus ();

  png_scanline_unfilter_core i_dut (
    .clk     (clk),
    .rst     (rst),
    .byte_in (byte_bus),
    .pix_out (pix_bus),
    .cfg     (cfg_bus)
  );

  always #1 clk = ~clk;

  // Unfilter state mirrored from the block.
  logic [BYTE_W-1:0]   line_store [STORE_DEPTH];
  logic [BYTE_W-1:0]   left_q     [BYTES_PER_PIXEL];
  logic [BYTE_W-1:0]   upleft_q   [BYTES_PER_PIXEL];
  int unsigned         col_cnt;
  int unsigned         row_cnt;
  logic [BYTE_W-1:0]   cur_filter;
  bit                  want_filter;
  logic [WIDTH_W-1:0]  cfg_width;
  logic [HEIGHT_W-1:0] cfg_height;
  bit                  row_done;
  bit                  image_done;

  pixel_beat_t pixel_q[$];
  int unsigned fail_count;
  int unsigned bytes_sent;
  int unsigned cycle_count;
  int unsigned send_gap_pct;
  int unsigned recv_stall_pct;

  function automatic logic [BYTE_W-1:0] paeth_pick(input logic [BYTE_W-1:0] a,
                                                   input logic [BYTE_W-1:0] b,
                                                   input logic [BYTE_W-1:0] c);
    int ia, ib, ic, pa, pb, pc;
    ia = a;
    ib = b;
    ic = c;
    pa = (ib > ic) ? ib - ic : ic - ib;
    pb = (ia > ic) ? ia - ic : ic - ia;
    pc = (ia + ib > 2 * ic) ? ia + ib - 2 * ic : 2 * ic - ia - ib;
    if (pa <= pb && pa <= pc) return a;
    if (pb <= pc) return b;
    return c;
  endfunction

  function automatic bit unfilter_byte(input logic [BYTE_W-1:0] raw, output pixel_beat_t beat);
    int unsigned       w, h, row_bytes, ch;
    logic [BYTE_W-1:0] left_b, up_b, ul_b, pred, value;
    logic [BYTE_W:0]   sum;
    bit                last_col, last_row;
    beat = '0;
    if (want_filter) begin
      cur_filter  = raw;
      want_filter = 1'b0;
      col_cnt     = 0;
      row_done    = 1'b0;
      image_done  = 1'b0;
      return 1'b0;
    end
    w = (cfg_width == 0) ? 1 : ((cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width);
    h = (cfg_height == 0) ? 1 : cfg_height;
    row_bytes = w * BYTES_PER_PIXEL;
    ch     = col_cnt % BYTES_PER_PIXEL;
    left_b = (col_cnt >= BYTES_PER_PIXEL) ? left_q[ch] : '0;
    up_b   = (row_cnt > 0) ? line_store[col_cnt] : '0;
    ul_b   = (row_cnt > 0 && col_cnt >= BYTES_PER_PIXEL) ? upleft_q[ch] : '0;
    sum    = {1'b0, left_b} + {1'b0, up_b};
    case (cur_filter)
      FILT_NONE:  pred = '0;
      FILT_SUB:   pred = left_b;
      FILT_UP:    pred = up_b;
      FILT_AVG:   pred = sum[BYTE_W:1];
      FILT_PAETH: pred = paeth_pick(left_b, up_b, ul_b);
      default:    pred = '0;
    endcase
    value = raw + pred;
    upleft_q[ch]        = up_b;
    left_q[ch]          = value;
    line_store[col_cnt] = value;
    last_col = (col_cnt + 1 >= row_bytes);
    last_row = (row_cnt + 1 >= h);
    beat.pixel_byte = value;
    beat.row_end    = last_col;
    beat.image_end  = last_col && last_row;
    if (last_col) begin
      col_cnt     = 0;
      want_filter = 1'b1;
      row_cnt     = last_row ? 0 : row_cnt + 1;
    end else begin
      col_cnt++;
    end
    row_done   = last_col;
    image_done = last_col && last_row;
    return 1'b1;
  endfunction

  function automatic logic [BYTE_W-1:0] random_sample();
    if ($urandom_range(7) == 0) return ($urandom_range(1) == 0) ? 8'h00 : 8'hFF;
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [BYTE_W-1:0] random_filter();
    if ($urandom_range(9) == 0) return 8'($urandom_range(255, 5));
    return 8'($urandom_range(4));
  endfunction

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    pixel_beat_t beat;
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      byte_bus.valid <= 1'b0;
      @(negedge clk);
    end
    byte_bus.valid       <= 1'b1;
    byte_bus.stream_byte <= b;
    do @(posedge clk); while (!byte_bus.ready);
    if (unfilter_byte(b, beat)) pixel_q.push_back(beat);
    bytes_sent++;
  endtask

  task automatic send_row(input logic [BYTE_W-1:0] filt, input bit fixed_data);
    logic [BYTE_W-1:0] pattern [8];
    int unsigned       k;
    pattern = '{8'hFF, 8'h00, 8'h80, 8'h7F, 8'h01, 8'hFE, 8'h40, 8'hC0};
    k = 0;
    send_byte(filt);
    do begin
      send_byte(fixed_data ? pattern[k % 8] : random_sample());
      k++;
    end while (!row_done);
  endtask

  task automatic drain();
    @(negedge clk);
    byte_bus.valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_bus.valid     <= 1'b1;
    cfg_bus.reg_index <= idx;
    cfg_bus.data      <= data;
    do @(posedge clk); while (!cfg_bus.ready);
    if (idx == CFG_IMAGE_WIDTH) cfg_width = data[WIDTH_W-1:0];
    else if (idx == CFG_IMAGE_HEIGHT) cfg_height = data[HEIGHT_W-1:0];
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
    drain();
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
  endtask

  task automatic test_reset_values();
    send_row(FILT_SUB, 1'b1);
    send_row(FILT_UP, 1'b1);
  endtask

  task automatic test_filter_types();
    configure(16'd2, 16'd7);
    send_row(FILT_NONE, 1'b1);
    send_row(FILT_SUB, 1'b1);
    send_row(FILT_PAETH, 1'b1);
    drain();
    write_reg(CFG_IMAGE_WIDTH, 16'd1);
    send_row(FILT_UP, 1'b1);
    send_row(FILT_AVG, 1'b1);
    send_row(8'd5, 1'b1);
    send_row(8'd255, 1'b1);
  endtask

  task automatic test_width_height_limits();
    configure(16'h0000, 16'h0000);
    send_row(FILT_PAETH, 1'b0);
    send_row(FILT_AVG, 1'b0);
    configure(16'hFFFF, 16'd2);
    send_byte(FILT_SUB);
    repeat (60) send_byte(random_sample());
    drain();
    write_reg(CFG_IMAGE_WIDTH, 16'd1);
    send_byte(random_sample());
    send_row(FILT_PAETH, 1'b0);
  endtask

  task automatic test_mid_image_writes();
    configure(16'hF803, 16'hFFFF);
    send_row(FILT_NONE, 1'b0);
    send_row(FILT_PAETH, 1'b0);
    send_row(FILT_AVG, 1'b0);
    drain();
    write_reg(CFG_IMAGE_HEIGHT, 16'd2);
    send_row(FILT_UP, 1'b0);
    configure(16'd5, 16'd2);
    send_byte(FILT_SUB);
    repeat (7) send_byte(random_sample());
    drain();
    write_reg(CFG_IMAGE_WIDTH, 16'd1);
    send_byte(random_sample());
    send_row(FILT_PAETH, 1'b0);
  endtask

  task automatic test_random_stream(input int unsigned n_bytes);
    int unsigned stop_at, w;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(2) == 0) begin
        w = ($urandom_range(9) == 0) ? $urandom_range(48, 9) : $urandom_range(8, 1);
        configure({5'($urandom_range(31)), 11'(w)}, 16'($urandom_range(4, 1)));
      end
      do begin
        send_row(random_filter(), 1'b0);
        if (!image_done && $urandom_range(19) == 0) begin
          drain();
          write_reg(CFG_IMAGE_HEIGHT, 16'($urandom_range(5, 1)));
        end else if (!image_done && $urandom_range(19) == 0) begin
          drain();
          w = (cfg_width == 0) ? 1 : cfg_width;
          write_reg(CFG_IMAGE_WIDTH, 16'($urandom_range(w, 1)));
        end
      end while (!image_done);
    end
  endtask

  always @(negedge clk) pix_bus.ready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin : check_beats
    pixel_beat_t want;
    if (!rst && pix_bus.valid && pix_bus.ready) begin
      if (pixel_q.size() == 0) begin
        $display("%0t: unexpected beat: expected none, actual byte %02h row_end %b image_end %b",
                 $time, pix_bus.pixel_byte, pix_bus.row_end, pix_bus.image_end);
        fail_count++;
      end else begin
        want = pixel_q.pop_front();
        if (pix_bus.pixel_byte !== want.pixel_byte) begin
          $display("%0t: pixel_byte expected %02h actual %02h",
                   $time, want.pixel_byte, pix_bus.pixel_byte);
          fail_count++;
        end
        if (pix_bus.row_end !== want.row_end) begin
          $display("%0t: row_end expected %b actual %b", $time, want.row_end, pix_bus.row_end);
          fail_count++;
        end
        if (pix_bus.image_end !== want.image_end) begin
          $display("%0t: image_end expected %b actual %b",
                   $time, want.image_end, pix_bus.image_end);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= MAX_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    byte_bus.valid       = 1'b0;
    byte_bus.stream_byte = '0;
    cfg_bus.valid        = 1'b0;
    cfg_bus.reg_index    = CFG_IMAGE_WIDTH;
    cfg_bus.data         = '0;
    pix_bus.ready        = 1'b0;
    foreach (line_store[i]) line_store[i] = '0;
    foreach (left_q[i]) begin
      left_q[i]   = '0;
      upleft_q[i] = '0;
    end
    col_cnt        = 0;
    row_cnt        = 0;
    cur_filter     = FILT_NONE;
    want_filter    = 1'b1;
    cfg_width      = 1;
    cfg_height     = 1;
    row_done       = 1'b0;
    image_done     = 1'b0;
    fail_count     = 0;
    bytes_sent     = 0;
    cycle_count    = 0;
    send_gap_pct   = 23;
    recv_stall_pct = 55;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_values();
    test_filter_types();
    test_width_height_limits();
    test_mid_image_writes();
    test_random_stream(380);
    send_gap_pct   = 55;
    recv_stall_pct = 23;
    test_random_stream(380);
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    test_random_stream(380);
    drain();

    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
design/psu_pkg.sv
design/psu_ifs.sv
design/psu_ram.sv
design/psu_ctrl.sv
design/psu_recon.sv
design/png_scanline_unfilter_core.sv
design/psu_checker.sv
tb/sv/tb.sv
